### rtl/snf_pkg.sv
package snf_pkg;

    localparam int STEP_W = 8;
    localparam int BASE_W = 24;
    localparam int OCT_W  = 5;
    localparam int FREQ_W = 32;
    localparam int NET_W  = 8;
    localparam int QUOT_W = 7;
    localparam int REM_W  = 4;
    localparam int SEMI_W = 4;
    localparam int Q16_W  = 17;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register word index, taken from paddr[3:2]
    localparam logic [1:0] REG_ROOT_FREQ    = 2'd0;
    localparam logic [1:0] REG_OCTAVE_SHIFT = 2'd1;
    localparam logic [1:0] REG_SCALE_SELECT = 2'd2;

    localparam logic [BASE_W-1:0] ROOT_FREQ_RESET = 24'd112640;

    typedef enum logic [1:0] {
        SCALE_MAJOR_PENT = 2'd0,
        SCALE_MINOR_PENT = 2'd1,
        SCALE_BLUES      = 2'd2,
        SCALE_CHROMATIC  = 2'd3
    } scale_t;

    function automatic logic [SEMI_W-1:0] semitone_of(scale_t scale, logic [REM_W-1:0] deg);
        logic [SEMI_W-1:0] semi;
        semi = '0;
        unique case (scale)
            SCALE_MAJOR_PENT:
            begin
                case (deg)
                    4'd0:    semi = 4'd0;
                    4'd1:    semi = 4'd2;
                    4'd2:    semi = 4'd4;
                    4'd3:    semi = 4'd7;
                    4'd4:    semi = 4'd9;
                    default: semi = 4'd0;
                endcase
            end
            SCALE_MINOR_PENT:
            begin
                case (deg)
                    4'd0:    semi = 4'd0;
                    4'd1:    semi = 4'd3;
                    4'd2:    semi = 4'd5;
                    4'd3:    semi = 4'd7;
                    4'd4:    semi = 4'd10;
                    default: semi = 4'd0;
                endcase
            end
            SCALE_BLUES:
            begin
                case (deg)
                    4'd0:    semi = 4'd0;
                    4'd1:    semi = 4'd3;
                    4'd2:    semi = 4'd5;
                    4'd3:    semi = 4'd6;
                    4'd4:    semi = 4'd7;
                    4'd5:    semi = 4'd10;
                    default: semi = 4'd0;
                endcase
            end
            SCALE_CHROMATIC:
            begin
                semi = deg;
            end
        endcase
        return semi;
    endfunction

    // 2^(k/12) in Q1.16, rounded to nearest
    function automatic logic [Q16_W-1:0] ratio_q16(logic [SEMI_W-1:0] semi);
        logic [Q16_W-1:0] r;
        case (semi)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd69433;
            4'd2:    r = 17'd73562;
            4'd3:    r = 17'd77936;
            4'd4:    r = 17'd82570;
            4'd5:    r = 17'd87480;
            4'd6:    r = 17'd92682;
            4'd7:    r = 17'd98193;
            4'd8:    r = 17'd104032;
            4'd9:    r = 17'd110218;
            4'd10:   r = 17'd116772;
            4'd11:   r = 17'd123715;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

### rtl/scale_note_frequency.sv
// throughput: one step per cycle while the output is not stalled; three register
// stages (degree and ratio lookup, multiplier, output shift and clamp) each hand
// on to the next when it moves
// reset: asynchronous, active low; empties the pipeline and loads the registers
// with 440 Hz base frequency, no octave shift and major pentatonic
module scale_note_frequency
    import snf_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] step_number
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [31:0] frequency
    output logic              m_tuser,   // [0] saturated
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int PROD_W = BASE_W + RATIO_FRAC_BITS + 1;

    logic [BASE_W-1:0]        root_freq_reg;
    logic signed [OCT_W-1:0]  octave_reg;
    scale_t                   scale_reg;
    logic                     cfg_write;

    logic                     deg_valid;
    logic                     deg_ready;
    logic [RATIO_FRAC_BITS:0] deg_ratio;
    logic signed [NET_W-1:0]  deg_net;
    logic                     mul_valid;
    logic                     mul_ready;
    logic [PROD_W-1:0]        mul_product;
    logic signed [NET_W-1:0]  mul_net;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_freq_reg <= ROOT_FREQ_RESET;
            octave_reg    <= '0;
            scale_reg     <= SCALE_MAJOR_PENT;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_ROOT_FREQ:    root_freq_reg <= pwdata[BASE_W-1:0];
                REG_OCTAVE_SHIFT: octave_reg    <= signed'(pwdata[OCT_W-1:0]);
                REG_SCALE_SELECT: scale_reg     <= scale_t'(pwdata[1:0]);
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ROOT_FREQ:    prdata = APB_DW'(root_freq_reg);
            REG_OCTAVE_SHIFT: prdata = APB_DW'(unsigned'(octave_reg));
            REG_SCALE_SELECT: prdata = APB_DW'(scale_reg);
            default:          prdata = '0;
        endcase
    end

    snf_degree #(
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_degree (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .step_number  (signed'(s_tdata)),
        .scale_select (scale_reg),
        .octave_shift (octave_reg),
        .out_valid    (deg_valid),
        .out_ready    (deg_ready),
        .ratio        (deg_ratio),
        .net_shift    (deg_net)
    );

    snf_mult #(
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_mult (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (deg_valid),
        .in_ready       (deg_ready),
        .ratio          (deg_ratio),
        .net_in         (deg_net),
        .root_frequency (root_freq_reg),
        .out_valid      (mul_valid),
        .out_ready      (mul_ready),
        .product        (mul_product),
        .net_out        (mul_net)
    );

    snf_shift #(
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_shift (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .product   (mul_product),
        .net_shift (mul_net),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .frequency (m_tdata),
        .saturated (m_tuser)
    );

`ifndef NO_ASSERTIONS
    // an accepted step always lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> deg_valid)
        else $error("accepted step not held in first stage");

    // input back-pressure only when every stage is occupied
    a_full_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> deg_valid && mul_valid && m_tvalid)
        else $error("input stalled with a free stage");

    // a stalled middle stage keeps its item
    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mul_valid && !mul_ready |=> mul_valid)
        else $error("multiplier stage dropped an item");

    // clamping always gives the all-ones frequency
    a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 32'hFFFF_FFFF)
        else $error("saturated result not clamped");
`endif

endmodule

### rtl/snf_degree.sv
module snf_degree
    import snf_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [STEP_W-1:0] step_number,
    input  scale_t                   scale_select,
    input  logic signed [OCT_W-1:0]  octave_shift,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [RATIO_FRAC_BITS:0] ratio,
    output logic signed [NET_W-1:0]  net_shift
);

    localparam int RATIO_W = RATIO_FRAC_BITS + 1;
    localparam logic signed [NET_W-1:0] FRAC_SHIFT = NET_W'(RATIO_FRAC_BITS);

    logic                      valid_reg;
    logic                      valid_next;
    logic [RATIO_W-1:0]        ratio_reg;
    logic [RATIO_W-1:0]        ratio_next;
    logic signed [NET_W-1:0]   net_reg;
    logic signed [NET_W-1:0]   net_next;

    logic [8:0]                bias;
    logic [7:0]                recip;
    logic [3:0]                modulus;
    logic [5:0]                quot_off;
    logic [8:0]                biased;
    logic [16:0]               recip_prod;
    logic [5:0]                quot_u;
    logic [8:0]                quot_mul;
    logic [REM_W-1:0]          degree;
    logic signed [QUOT_W-1:0]  octave;
    logic [SEMI_W-1:0]         semi;
    logic [Q16_W-1:0]          ratio_tab;

    assign in_ready = !valid_reg || out_ready;

    // floored division by the scale length: bias the step positive by a multiple
    // of the length, divide by reciprocal multiply, then remove the bias quotient
    always_comb
    begin
        unique case (scale_select)
            SCALE_MAJOR_PENT, SCALE_MINOR_PENT:
            begin
                modulus  = 4'd5;
                bias     = 9'd130;
                recip    = 8'd205;
                quot_off = 6'd26;
            end
            SCALE_BLUES:
            begin
                modulus  = 4'd6;
                bias     = 9'd132;
                recip    = 8'd171;
                quot_off = 6'd22;
            end
            SCALE_CHROMATIC:
            begin
                modulus  = 4'd12;
                bias     = 9'd132;
                recip    = 8'd171;
                quot_off = 6'd11;
            end
        endcase
    end

    always_comb
    begin
        biased     = 9'(step_number) + bias;
        recip_prod = 17'(biased) * 17'(recip);
        if (scale_select == SCALE_CHROMATIC)
        begin
            quot_u = recip_prod[16:11];
        end
        else
        begin
            quot_u = 6'(recip_prod[16:10]);
        end
        quot_mul  = 9'(quot_u) * 9'(modulus);
        degree    = REM_W'(biased - quot_mul);
        octave    = signed'(QUOT_W'(quot_u)) - signed'(QUOT_W'(quot_off));
        semi      = semitone_of(scale_select, degree);
        ratio_tab = ratio_q16(semi);
        net_next  = NET_W'(octave) + NET_W'(octave_shift) - FRAC_SHIFT;
    end

    generate
        if (RATIO_FRAC_BITS >= 16)
        begin : g_ratio_up
            always_comb
            begin
                ratio_next = RATIO_W'(ratio_tab) << (RATIO_FRAC_BITS - 16);
            end
        end
        else
        begin : g_ratio_down
            localparam int DN = 16 - RATIO_FRAC_BITS;
            logic [Q16_W:0] rounded;
            always_comb
            begin
                rounded    = (Q16_W+1)'(ratio_tab) + ((Q16_W+1)'(1) << (DN - 1));
                ratio_next = RATIO_W'(rounded >> DN);
            end
        end
    endgenerate

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ratio_reg <= ratio_next;
            net_reg   <= net_next;
        end
    end

    assign out_valid = valid_reg;
    assign ratio     = ratio_reg;
    assign net_shift = net_reg;

endmodule

### rtl/snf_mult.sv
module snf_mult
    import snf_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [RATIO_FRAC_BITS:0]             ratio,
    input  logic signed [NET_W-1:0]              net_in,
    input  logic [BASE_W-1:0]                    root_frequency,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [BASE_W+RATIO_FRAC_BITS:0]      product,
    output logic signed [NET_W-1:0]              net_out
);

    localparam int PROD_W = BASE_W + RATIO_FRAC_BITS + 1;

    logic                    valid_reg;
    logic                    valid_next;
    logic [PROD_W-1:0]       prod_reg;
    logic [PROD_W-1:0]       prod_next;
    logic signed [NET_W-1:0] net_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        prod_next  = PROD_W'(root_frequency) * PROD_W'(ratio);
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_reg <= prod_next;
            net_reg  <= net_in;
        end
    end

    assign out_valid = valid_reg;
    assign product   = prod_reg;
    assign net_out   = net_reg;

endmodule

### rtl/snf_shift.sv
module snf_shift
    import snf_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [BASE_W+RATIO_FRAC_BITS:0] product,
    input  logic signed [NET_W-1:0]         net_shift,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [FREQ_W-1:0]               frequency,
    output logic                            saturated
);

    localparam int PROD_W = BASE_W + RATIO_FRAC_BITS + 1;
    localparam int WIDE_W = PROD_W + FREQ_W;

    logic                valid_reg;
    logic                valid_next;
    logic [FREQ_W-1:0]   freq_reg;
    logic [FREQ_W-1:0]   freq_next;
    logic                sat_reg;
    logic                sat_next;
    logic [WIDE_W-1:0]   left_val;
    logic [PROD_W-1:0]   right_val;
    logic [NET_W-1:0]    right_amt;
    logic                over;
    logic [FREQ_W-1:0]   low_word;

    assign in_ready = !valid_reg || out_ready;

    // net shift is at most one word width when non-negative
    always_comb
    begin
        left_val  = WIDE_W'(product) << net_shift[5:0];
        right_amt = NET_W'(-net_shift);
        if (right_amt >= NET_W'(PROD_W))
        begin
            right_val = '0;
        end
        else
        begin
            right_val = product >> right_amt;
        end
        if (!net_shift[NET_W-1])
        begin
            over     = |left_val[WIDE_W-1:FREQ_W];
            low_word = left_val[FREQ_W-1:0];
        end
        else
        begin
            over     = |right_val[PROD_W-1:FREQ_W];
            low_word = right_val[FREQ_W-1:0];
        end
        sat_next  = over;
        freq_next = over ? '1 : low_word;
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            freq_reg <= freq_next;
            sat_reg  <= sat_next;
        end
    end

    assign out_valid = valid_reg;
    assign frequency = freq_reg;
    assign saturated = sat_reg;

endmodule
